@@ rtl/core/lprd_pkg.sv @@
// shared constants, result type and codes for the length-prefixed record deframer
package lprd_pkg;

    // reflected form of the crc32c polynomial 0x1EDC6F41
    localparam logic [31:0] CRC_POLY_REFL = 32'h82F6_3B78;
    localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;

    // length word counts the checksum word as well as the payload
    localparam logic [31:0] LEN_OVERHEAD  = 32'd4;

    localparam int unsigned HDR_CNT_W     = 3;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_POS = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT_LEN = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic [31:0] payload_length;
        logic [31:0] carried_checksum;
        logic [31:0] computed_checksum;
        logic        checksum_match;
        logic        record_last;
        logic [1:0]  status;
    } res_t;

endpackage

@@ rtl/core/lprd_if.sv @@
// stream channel interfaces for the deframer input bytes and result beats
interface lprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_end;

    modport source (output valid, output in_byte, output buffer_end, input ready);
    modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

interface lprd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic [31:0] payload_length;
    logic [31:0] carried_checksum;
    logic [31:0] computed_checksum;
    logic        checksum_match;
    logic        record_last;
    logic [1:0]  status;

    modport source (
        output valid, output payload_byte, output byte_valid, output payload_length,
        output carried_checksum, output computed_checksum, output checksum_match,
        output record_last, output status, input ready
    );
    modport sink (
        input valid, input payload_byte, input byte_valid, input payload_length,
        input carried_checksum, input computed_checksum, input checksum_match,
        input record_last, input status, output ready
    );
endinterface

@@ rtl/core/lprd_crc8.sv @@
// one-byte update of a reflected crc32c register
module lprd_crc8 (
    input  logic [31:0] crc,
    input  logic [7:0]  data,
    output logic [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? lprd_pkg::CRC_POLY_REFL : 32'd0);
        end
        crc_out = c;
    end

endmodule

@@ rtl/core/lprd_parse.sv @@
// header assembly, payload counting and crc state, forms at most one result per byte
module lprd_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       data,
    input  logic             buf_end,
    output logic             has_result,
    output lprd_pkg::res_t   res
);

    logic                               in_payload_reg;
    logic [lprd_pkg::HDR_CNT_W-1:0]     header_count_reg;
    logic [31:0]                        length_word_reg;
    logic [31:0]                        checksum_word_reg;
    logic [31:0]                        bytes_left_reg;
    logic [31:0]                        crc_reg;

    logic                               in_payload_next;
    logic [lprd_pkg::HDR_CNT_W-1:0]     header_count_next;
    logic [31:0]                        length_word_next;
    logic [31:0]                        checksum_word_next;
    logic [31:0]                        bytes_left_next;
    logic [31:0]                        crc_next;

    logic [31:0] crc_upd;
    logic [31:0] comp;
    logic [31:0] plen;
    logic [31:0] hdr_plen;
    logic [31:0] left_dec;

    lprd_crc8 u_crc (
        .crc     (crc_reg),
        .data    (data),
        .crc_out (crc_upd)
    );

    assign comp     = crc_upd ^ lprd_pkg::CRC_ONES;
    assign plen     = length_word_reg - lprd_pkg::LEN_OVERHEAD;
    assign hdr_plen = length_word_next - lprd_pkg::LEN_OVERHEAD;
    assign left_dec = bytes_left_reg - 32'd1;

    always_comb
    begin
        in_payload_next    = in_payload_reg;
        header_count_next  = header_count_reg;
        length_word_next   = length_word_reg;
        checksum_word_next = checksum_word_reg;
        bytes_left_next    = bytes_left_reg;
        crc_next           = crc_reg;
        has_result         = 1'b0;
        res                = '0;

        if (!in_payload_reg)
        begin
            // little-endian byte insert into length or checksum word
            if (!header_count_reg[2])
            begin
                length_word_next[{header_count_reg[1:0], 3'b000} +: 8] = data;
            end
            else
            begin
                checksum_word_next[{header_count_reg[1:0], 3'b000} +: 8] = data;
            end

            if (header_count_reg != lprd_pkg::HDR_LAST_POS)
            begin
                header_count_next = header_count_reg + 1'b1;
                if (buf_end)
                begin
                    has_result      = 1'b1;
                    res.record_last = 1'b1;
                    res.status      = lprd_pkg::ST_TRUNCATED;
                end
            end
            else
            begin
                header_count_next = '0;
                if (length_word_next < lprd_pkg::LEN_OVERHEAD)
                begin
                    has_result           = 1'b1;
                    res.carried_checksum = checksum_word_next;
                    res.record_last      = 1'b1;
                    res.status           = lprd_pkg::ST_SHORT_LEN;
                end
                else if (length_word_next == lprd_pkg::LEN_OVERHEAD)
                begin
                    // empty payload: crc of nothing is zero
                    has_result           = 1'b1;
                    res.carried_checksum = checksum_word_next;
                    res.checksum_match   = (checksum_word_next == 32'd0);
                    res.record_last      = 1'b1;
                    res.status           = lprd_pkg::ST_OK;
                end
                else if (buf_end)
                begin
                    has_result           = 1'b1;
                    res.payload_length   = hdr_plen;
                    res.carried_checksum = checksum_word_next;
                    res.record_last      = 1'b1;
                    res.status           = lprd_pkg::ST_TRUNCATED;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    bytes_left_next = hdr_plen;
                    crc_next        = lprd_pkg::CRC_ONES;
                end
            end
        end
        else
        begin
            crc_next              = crc_upd;
            bytes_left_next       = left_dec;
            has_result            = 1'b1;
            res.payload_byte      = data;
            res.byte_valid        = 1'b1;
            res.payload_length    = plen;
            res.carried_checksum  = checksum_word_reg;
            res.computed_checksum = comp;
            if (left_dec == 32'd0)
            begin
                res.checksum_match = (comp == checksum_word_reg);
                res.record_last    = 1'b1;
                res.status         = lprd_pkg::ST_OK;
                in_payload_next    = 1'b0;
                header_count_next  = '0;
            end
            else if (buf_end)
            begin
                res.record_last = 1'b1;
                res.status      = lprd_pkg::ST_TRUNCATED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg    <= 1'b0;
            header_count_reg  <= '0;
            length_word_reg   <= '0;
            checksum_word_reg <= '0;
            bytes_left_reg    <= '0;
            crc_reg           <= lprd_pkg::CRC_ONES;
        end
        else if (advance)
        begin
            if (buf_end)
            begin
                // end of buffer always returns to a fresh start
                in_payload_reg    <= 1'b0;
                header_count_reg  <= '0;
                length_word_reg   <= '0;
                checksum_word_reg <= '0;
                bytes_left_reg    <= '0;
                crc_reg           <= lprd_pkg::CRC_ONES;
            end
            else
            begin
                in_payload_reg    <= in_payload_next;
                header_count_reg  <= header_count_next;
                length_word_reg   <= length_word_next;
                checksum_word_reg <= checksum_word_next;
                bytes_left_reg    <= bytes_left_next;
                crc_reg           <= crc_next;
            end
        end
    end

endmodule

@@ rtl/core/length_prefixed_record_deframer.sv @@
// top level of the length-prefixed record deframer with crc32c check
//
//  channel  dir  payload                                     meaning
//  rx       in   in_byte, buffer_end                         one buffer byte per beat
//  tx       out  payload_byte, byte_valid, payload_length,   zero or one result beat
//                carried_checksum, computed_checksum,        per input byte
//                checksum_match, record_last, status
//
// one byte per cycle unless a held result stalls the input; a byte passes through the input
// register, then parse and crc update into the result register
// header bytes give no beat except on errors; the 8th header byte may give a marker beat
// rst_n clears the parse state, the crc register to all ones, and both valid flags
// a held result stalls the input register only when the byte there would make a beat
module length_prefixed_record_deframer (
    input  logic           clk,
    input  logic           rst_n,
    lprd_in_if.sink        rx,
    lprd_out_if.source     tx
);

    logic           s1_valid_reg;
    logic [7:0]     s1_byte_reg;
    logic           s1_end_reg;
    logic           out_valid_reg;
    lprd_pkg::res_t res_reg;

    logic           has_result;
    lprd_pkg::res_t res_next;
    logic           s1_fire;
    logic           out_load;

    lprd_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_fire),
        .data       (s1_byte_reg),
        .buf_end    (s1_end_reg),
        .has_result (has_result),
        .res        (res_next)
    );

    // bytes that make no beat drain even while the result register is full
    assign s1_fire  = s1_valid_reg && (!has_result || !out_valid_reg || tx.ready);
    assign out_load = s1_fire && has_result;
    assign rx.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                s1_valid_reg <= rx.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tx.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            s1_byte_reg <= rx.in_byte;
            s1_end_reg  <= rx.buffer_end;
        end
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    assign tx.valid             = out_valid_reg;
    assign tx.payload_byte      = res_reg.payload_byte;
    assign tx.byte_valid        = res_reg.byte_valid;
    assign tx.payload_length    = res_reg.payload_length;
    assign tx.carried_checksum  = res_reg.carried_checksum;
    assign tx.computed_checksum = res_reg.computed_checksum;
    assign tx.checksum_match    = res_reg.checksum_match;
    assign tx.record_last       = res_reg.record_last;
    assign tx.status            = res_reg.status;

endmodule

@@ verif/lprd_tb_pkg.sv @@
// crc32c byte update shared by the deframer stimulus builder and its checker
`timescale 1ns / 1ps

package lprd_tb_pkg;

    // one reflected crc32c step over a byte, lsb first
    function automatic logic [31:0] crc32c_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        int          k;
        c = crc ^ {24'h0, data};
        for (k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ lprd_pkg::CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ verif/deframer_checker.sv @@
// checker that parses the deframer input bytes and compares every result beat
`timescale 1ns / 1ps

module deframer_checker (
    input  logic        clk,
    input  logic        rst_n,
    lprd_in_if          rx,
    lprd_out_if         tx,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned beats_in,
    output int unsigned beats_out,
    output int unsigned crc_good,
    output int unsigned crc_bad,
    output int unsigned short_len,
    output int unsigned truncated
);

    // parser state mirrored from the block
    logic        in_body;
    logic [2:0]  hdr_pos;
    logic [31:0] len_w;
    logic [31:0] chk_w;
    logic [31:0] remain;
    logic [31:0] crc_state;

    lprd_pkg::res_t predicted_beats[$];
    int unsigned fails;
    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_good;
    int unsigned n_bad;
    int unsigned n_short;
    int unsigned n_trunc;

    task automatic clear_parser();
        in_body   = 1'b0;
        hdr_pos   = '0;
        len_w     = '0;
        chk_w     = '0;
        remain    = '0;
        crc_state = lprd_pkg::CRC_ONES;
    endtask

    // works out the beat, if any, that one input byte causes
    task automatic parse_byte(input logic [7:0] b, input logic buf_end);
        lprd_pkg::res_t r;
        logic        emit;
        logic [31:0] comp;
        r    = '0;
        emit = 1'b0;
        if (!in_body)
        begin
            if (hdr_pos < 3'd4)
                len_w[{hdr_pos[1:0], 3'b000} +: 8] = b;
            else
                chk_w[{hdr_pos[1:0], 3'b000} +: 8] = b;
            if (hdr_pos != lprd_pkg::HDR_LAST_POS)
            begin
                hdr_pos = hdr_pos + 3'd1;
                if (buf_end)
                begin
                    r.record_last = 1'b1;
                    r.status      = lprd_pkg::ST_TRUNCATED;
                    emit          = 1'b1;
                end
            end
            else
            begin
                hdr_pos = '0;
                if (len_w < lprd_pkg::LEN_OVERHEAD)
                begin
                    r.carried_checksum = chk_w;
                    r.record_last      = 1'b1;
                    r.status           = lprd_pkg::ST_SHORT_LEN;
                    emit               = 1'b1;
                end
                else if (len_w == lprd_pkg::LEN_OVERHEAD)
                begin
                    // empty payload: crc of nothing is zero
                    r.carried_checksum = chk_w;
                    r.checksum_match   = (chk_w == 32'h0);
                    r.record_last      = 1'b1;
                    r.status           = lprd_pkg::ST_OK;
                    emit               = 1'b1;
                end
                else if (buf_end)
                begin
                    r.payload_length   = len_w - lprd_pkg::LEN_OVERHEAD;
                    r.carried_checksum = chk_w;
                    r.record_last      = 1'b1;
                    r.status           = lprd_pkg::ST_TRUNCATED;
                    emit               = 1'b1;
                end
                else
                begin
                    in_body   = 1'b1;
                    remain    = len_w - lprd_pkg::LEN_OVERHEAD;
                    crc_state = lprd_pkg::CRC_ONES;
                end
            end
        end
        else
        begin
            crc_state            = lprd_tb_pkg::crc32c_step(crc_state, b);
            comp                 = crc_state ^ lprd_pkg::CRC_ONES;
            remain               = remain - 32'd1;
            r.payload_byte       = b;
            r.byte_valid         = 1'b1;
            r.payload_length     = len_w - lprd_pkg::LEN_OVERHEAD;
            r.carried_checksum   = chk_w;
            r.computed_checksum  = comp;
            emit                 = 1'b1;
            if (remain == 32'h0)
            begin
                r.checksum_match = (comp == chk_w);
                r.record_last    = 1'b1;
                r.status         = lprd_pkg::ST_OK;
                in_body          = 1'b0;
                hdr_pos          = '0;
            end
            else if (buf_end)
            begin
                r.record_last = 1'b1;
                r.status      = lprd_pkg::ST_TRUNCATED;
            end
        end
        if (emit)
            predicted_beats.insert(predicted_beats.size(), r);
        if (buf_end)
            clear_parser();
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lprd_pkg::res_t want;
        if (!rst_n)
        begin
            clear_parser();
            predicted_beats.delete();
            fails   = 0;
            n_in    = 0;
            n_out   = 0;
            n_good  = 0;
            n_bad   = 0;
            n_short = 0;
            n_trunc = 0;
        end
        else
        begin
            // predict first so a same-cycle result would still find its expectation
            if (rx.valid && rx.ready)
            begin
                parse_byte(rx.in_byte, rx.buffer_end);
                n_in++;
            end
            if (tx.valid && tx.ready)
            begin
                n_out++;
                if (predicted_beats.size() == 0)
                begin
                    $error("result beat with no expectation pending");
                    fails++;
                end
                else
                begin
                    want = predicted_beats.pop_front();
                    check_field("payload_byte", {24'h0, want.payload_byte}, {24'h0, tx.payload_byte});
                    check_field("byte_valid", {31'h0, want.byte_valid}, {31'h0, tx.byte_valid});
                    check_field("payload_length", want.payload_length, tx.payload_length);
                    check_field("carried_checksum", want.carried_checksum, tx.carried_checksum);
                    check_field("computed_checksum", want.computed_checksum,
                                tx.computed_checksum);
                    check_field("checksum_match", {31'h0, want.checksum_match},
                                {31'h0, tx.checksum_match});
                    check_field("record_last", {31'h0, want.record_last}, {31'h0, tx.record_last});
                    check_field("status", {30'h0, want.status}, {30'h0, tx.status});
                    if (want.record_last)
                    begin
                        if (want.status == lprd_pkg::ST_SHORT_LEN)
                            n_short++;
                        else if (want.status == lprd_pkg::ST_TRUNCATED)
                            n_trunc++;
                        else if (want.checksum_match)
                            n_good++;
                        else
                            n_bad++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= predicted_beats.size();
        beats_in   <= n_in;
        beats_out  <= n_out;
        crc_good   <= n_good;
        crc_bad    <= n_bad;
        short_len  <= n_short;
        truncated  <= n_trunc;
    end

endmodule

@@ verif/tb_length_prefixed_record_deframer.sv @@
// testbench top: builds record buffers, drives the deframer and gives the verdict
`timescale 1ns / 1ps

module tb_length_prefixed_record_deframer;

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned RANDOM_BEATS = 1050;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum logic [1:0] { CHK_GOOD, CHK_FLIP, CHK_FIXED } chk_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       buf_end;
    } rx_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_cnt = 0;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned crc_good;
    int unsigned crc_bad;
    int unsigned short_len;
    int unsigned truncated;

    rx_beat_t    buffer_bytes[$];

    lprd_in_if  rx ();
    lprd_out_if tx ();

    length_prefixed_record_deframer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .tx    (tx)
    );

    deframer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .tx         (tx),
        .fail_count (fail_count),
        .pending    (pending),
        .beats_in   (beats_in),
        .beats_out  (beats_out),
        .crc_good   (crc_good),
        .crc_bad    (crc_bad),
        .short_len  (short_len),
        .truncated  (truncated)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_length_prefixed_record_deframer: errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one record: length word, checksum word, body; keep cuts it short and ends the buffer
    task automatic queue_record(input logic [31:0] len_word, input int unsigned body_len,
                                input chk_mode_t mode, input logic [31:0] fixed_chk,
                                input int unsigned keep, input bit close_buf);
        rx_beat_t    rec[$];
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [31:0] chk;
        int unsigned i;
        crc = lprd_pkg::CRC_ONES;
        for (i = 0; i < body_len; i++)
        begin
            body.insert(body.size(), 8'($urandom_range(0, 255)));
            crc = lprd_tb_pkg::crc32c_step(crc, body[i]);
        end
        crc = crc ^ lprd_pkg::CRC_ONES;
        case (mode)
            CHK_GOOD: chk = crc;
            CHK_FLIP: chk = crc ^ (32'h1 << $urandom_range(0, 31));
            default:  chk = fixed_chk;
        endcase
        for (i = 0; i < 4; i++)
            rec.insert(rec.size(), rx_beat_t'({len_word[8*i +: 8], 1'b0}));
        for (i = 0; i < 4; i++)
            rec.insert(rec.size(), rx_beat_t'({chk[8*i +: 8], 1'b0}));
        for (i = 0; i < body_len; i++)
            rec.insert(rec.size(), rx_beat_t'({body[i], 1'b0}));
        while (keep != 0 && rec.size() > keep)
            void'(rec.pop_back());
        if (keep != 0 || close_buf)
            rec[rec.size() - 1].buf_end = 1'b1;
        for (i = 0; i < rec.size(); i++)
            buffer_bytes.insert(buffer_bytes.size(), rec[i]);
    endtask

    task automatic build_buffers();
        int unsigned pick;
        int unsigned body;
        int unsigned stop_at;
        // length below four with an all-ones checksum
        queue_record(32'h0, 0, CHK_FIXED, 32'hFFFF_FFFF, 0, 1'b0);
        // empty payload, zero checksum matches
        queue_record(lprd_pkg::LEN_OVERHEAD, 0, CHK_GOOD, 32'h0, 0, 1'b0);
        // largest length word, buffer ends on the last header byte
        queue_record(32'hFFFF_FFFF, 0, CHK_FIXED, 32'h0, 8, 1'b0);
        stop_at = buffer_bytes.size() + RANDOM_BEATS;
        while (buffer_bytes.size() < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 68)
            begin
                if ($urandom_range(0, 9) == 0)
                    body = 0;
                else if ($urandom_range(0, 9) == 0)
                    body = $urandom_range(25, 80);
                else
                    body = $urandom_range(1, 24);
                queue_record(body + 4, body,
                             ($urandom_range(0, 3) == 0) ? CHK_FLIP : CHK_GOOD,
                             32'h0, 0, $urandom_range(0, 11) == 0);
            end
            else if (pick < 76)
            begin
                queue_record($urandom_range(0, 3), 0, CHK_FIXED, $urandom, 0,
                             $urandom_range(0, 9) == 0);
            end
            else if (pick < 90)
            begin
                // cut inside the header, on its last byte, or inside the body
                body = $urandom_range(1, 30);
                queue_record(body + 4, body, CHK_GOOD, 32'h0,
                             ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, body + 7), 1'b0);
            end
            else
            begin
                // garbage header, always closed by a buffer end
                body = $urandom_range(0, 24);
                queue_record($urandom, body, CHK_FIXED, $urandom,
                             $urandom_range(1, body + 8), 1'b0);
            end
        end
    endtask

    initial
    begin
        int unsigned n;
        tx.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                tx.ready <= 1'b1;
                repeat ($urandom_range(40, 160)) @(posedge clk);
            end
            else
            begin
                n = idle_len(1'b0);
                if (n != 0)
                begin
                    tx.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                tx.ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned idx;
        int unsigned n;
        int unsigned half;
        bit          calm;
        rst_n         <= 1'b0;
        rx.valid      <= 1'b0;
        rx.in_byte    <= '0;
        rx.buffer_end <= 1'b0;
        calm = 1'b0;
        build_buffers();
        half = buffer_bytes.size() / 2;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (idx = 0; idx < buffer_bytes.size(); idx++)
        begin
            if (idx % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (idx == half)
            begin
                // hold off until the block has drained everything
                rx.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            n = idle_len(calm);
            if (n != 0)
            begin
                rx.valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rx.valid      <= 1'b1;
            rx.in_byte    <= buffer_bytes[idx].data;
            rx.buffer_end <= buffer_bytes[idx].buf_end;
            @(posedge clk);
            while (!rx.ready)
                @(posedge clk);
        end
        rx.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("run covered %0d input beats and %0d result beats", beats_in, beats_out);
        $display("records: %0d crc match, %0d crc mismatch, %0d short length, %0d truncated",
                 crc_good, crc_bad, short_len, truncated);
        if (fail_count == 0)
            $display("tb_length_prefixed_record_deframer: clean");
        else
            $display("tb_length_prefixed_record_deframer: errors");
        $finish;
    end

endmodule
